@@ design/kaat_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package kaat_pkg;
	localparam int KEY_W = 16;
	localparam int SAMPLE_W = 32;
	localparam int CNT_W = 32;
	localparam int SUM_W = 64;
	localparam int AVG_W = 32;
	localparam int FRAC_BITS = 16;

	typedef enum logic [2:0] {
		ST_ACC   = 3'd0,
		ST_NEW   = 3'd1,
		ST_FULL  = 3'd2,
		ST_DIS   = 3'd3,
		ST_ENTRY = 3'd4,
		ST_EMPTY = 3'd5
	} status_t;

	typedef enum logic {
		FN_ADD   = 1'b0,
		FN_FLUSH = 1'b1
	} func_t;

	typedef struct packed {
		func_t                func;
		logic [KEY_W-1:0]     key;
		logic [SAMPLE_W-1:0]  sample;
	} req_t;

	typedef struct packed {
		status_t              status;
		logic [KEY_W-1:0]     key;
		logic [CNT_W-1:0]     count;
		logic [AVG_W-1:0]     average;
		logic                 last;
	} res_t;
endpackage
`default_nettype wire

@@ design/kaat_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kaat_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ design/kaat_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kaat_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire kaat_pkg::req_t      in_req,
	output logic                     q_valid,
	input  wire logic                q_ready,
	output kaat_pkg::req_t           q_req
);
	import kaat_pkg::*;

	// two-entry request queue
	req_t   buf_q [2];
	logic   wp_q, rp_q;
	logic   [1:0] cnt_q;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_req    = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			buf_q[wp_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_valid && in_ready) begin
				wp_q <= ~wp_q;
			end
			if (q_valid && q_ready) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'((in_valid && in_ready) ? 1 : 0)
				- 2'((q_valid && q_ready) ? 1 : 0);
		end
	end
endmodule
`default_nettype wire

@@ design/kaat_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kaat_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kaat_pkg::SUM_W-1:0]  sum,
	input  wire logic [kaat_pkg::CNT_W-1:0]  count,
	output logic                             done,
	output logic [kaat_pkg::AVG_W-1:0]       average
);
	import kaat_pkg::*;

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W:0]    rem_q;
	logic [CNT_W-1:0]  den_q;
	logic              neg_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    shifted;
	logic [SUM_W-1:0]  mag;

	assign mag     = sum[SUM_W-1] ? (~sum + 1'b1) : sum;
	assign shifted = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_comb begin
		if (neg_q) begin
			if (quo_q > SUM_W'(64'h8000_0000)) begin
				average = 32'h8000_0000;
			end else begin
				average = AVG_W'(~quo_q + 1'b1);
			end
		end else begin
			if (quo_q > SUM_W'(64'h7FFF_FFFF)) begin
				average = 32'h7FFF_FFFF;
			end else begin
				average = quo_q[AVG_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			neg_q  <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(SUM_W);
				quo_q  <= mag;
				rem_q  <= '0;
				den_q  <= count;
				neg_q  <= sum[SUM_W-1];
			end else if (busy_q) begin
				if (!trial[CNT_W]) begin
					rem_q <= trial;
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end
endmodule
`default_nettype wire

@@ design/kaat_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module kaat_back #(
	parameter int SLOTS = 56
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                enable,
	input  wire logic                q_valid,
	output logic                     q_ready,
	input  wire kaat_pkg::req_t      q_req,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output kaat_pkg::res_t           out_res
);
	import kaat_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int RW = KEY_W + CNT_W + SUM_W;
	localparam logic [SUM_W-1:0] SMAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SMIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_WR, S_EMIT, S_FRD, S_FCHK, S_FDIV, S_FEMIT
	} state_t;

	state_t          state_q;
	logic [SLOTS-1:0] valid_q;
	logic [IW-1:0]   idx_q;
	logic [IW-1:0]   free_q;
	logic            free_ok_q;
	req_t            req_q;
	logic            we;
	logic [IW-1:0]   waddr;
	logic [RW-1:0]   wdata;
	logic [RW-1:0]   rdata;
	logic [KEY_W-1:0] r_key;
	logic [CNT_W-1:0] r_cnt;
	logic [SUM_W-1:0] r_sum;
	logic [SUM_W-1:0] sext;
	logic [SUM_W-1:0] nsum;
	logic            div_start;
	logic            div_done;
	logic [AVG_W-1:0] avg;
	logic            more;
	logic [CNT_W-1:0] ncnt;

	assign {r_key, r_cnt, r_sum} = rdata;
	assign sext = {{(SUM_W-SAMPLE_W){req_q.sample[SAMPLE_W-1]}}, req_q.sample};
	assign nsum = r_sum + sext;
	assign ncnt = r_cnt + 1'b1;

	always_comb begin
		more = 1'b0;
		for (int i = 0; i < SLOTS; i++) begin
			if (valid_q[i] && (IW'(i) > idx_q)) begin
				more = 1'b1;
			end
		end
	end

	kaat_ram #(.WIDTH(RW), .DEPTH(SLOTS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_q), .rdata(rdata)
	);

	kaat_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.sum(r_sum), .count(r_cnt), .done(div_done), .average(avg)
	);

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = rdata;
		if (state_q == S_CHK && valid_q[idx_q] && r_key == req_q.key) begin
			we = (r_cnt != '1);
			if (!sext[SUM_W-1] && !r_sum[SUM_W-1] && nsum[SUM_W-1]) begin
				wdata = {r_key, ncnt, SMAX};
			end else if (sext[SUM_W-1] && r_sum[SUM_W-1] && !nsum[SUM_W-1]) begin
				wdata = {r_key, ncnt, SMIN};
			end else begin
				wdata = {r_key, ncnt, nsum};
			end
		end else if (state_q == S_WR) begin
			we    = free_ok_q;
			waddr = free_q;
			wdata = {req_q.key, CNT_W'(1), sext};
		end
	end

	assign q_ready   = (state_q == S_IDLE);
	assign div_start = (state_q == S_FCHK) && valid_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			valid_q   <= '0;
			idx_q     <= '0;
			free_q    <= '0;
			free_ok_q <= 1'b0;
			out_valid <= 1'b0;
			out_res   <= '0;
			req_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						req_q     <= q_req;
						idx_q     <= '0;
						free_ok_q <= 1'b0;
						if (q_req.func == FN_FLUSH) begin
							if (valid_q == '0) begin
								out_res   <= '{ST_EMPTY, '0, '0, '0, 1'b1};
								out_valid <= 1'b1;
								state_q   <= S_EMIT;
							end else begin
								state_q <= S_FRD;
							end
						end else if (!enable) begin
							out_res   <= '{ST_DIS, q_req.key, '0, '0, 1'b1};
							out_valid <= 1'b1;
							state_q   <= S_EMIT;
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					if (valid_q[idx_q] && r_key == req_q.key) begin
						out_res   <= '{ST_ACC, r_key, (r_cnt == '1) ? r_cnt : ncnt, '0, 1'b1};
						out_valid <= 1'b1;
						state_q   <= S_EMIT;
					end else begin
						if (!valid_q[idx_q] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q    <= idx_q;
						end
						if (idx_q == IW'(SLOTS - 1)) begin
							state_q <= S_WR;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_WR: begin
					if (free_ok_q) begin
						valid_q[free_q] <= 1'b1;
						out_res <= '{ST_NEW, req_q.key, CNT_W'(1), '0, 1'b1};
					end else begin
						out_res <= '{ST_FULL, req_q.key, '0, '0, 1'b1};
					end
					out_valid <= 1'b1;
					state_q   <= S_EMIT;
				end
				S_EMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (valid_q[idx_q]) begin
						state_q <= S_FDIV;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= S_FRD;
					end
				end
				S_FDIV: begin
					if (div_done) begin
						out_res   <= '{ST_ENTRY, r_key, r_cnt, avg, !more};
						out_valid <= 1'b1;
						valid_q[idx_q] <= 1'b0;
						state_q   <= S_FEMIT;
					end
				end
				S_FEMIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (out_res.last) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= S_FRD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/keyed_average_aggregation_table_top.sv @@
// channel   | dir | handshake                         | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready      | tdata, tuser
// m_axis    | out | m_axis_tvalid / m_axis_tready      | tdata, tuser, tlast
// cfg       | in  | cfg_valid / cfg_ready              | cfg_data (enable)
// An add does one RAM read and check per slot, stopping at the slot whose key matches.
// A flush reads the slots in turn and runs the serial divider once per used slot.
// A two-entry request queue takes items while the table engine works.
// arst_n clears the table valid bits, enable and all control state.
// Stalls on m_axis hold the engine on the pending result.
`timescale 1ns / 1ps
`default_nettype none
module keyed_average_aggregation_table_top #(
	parameter int SLOT_COUNT = 56
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,   // key[15:0], sample_value[47:16]
	input  wire logic        s_axis_tuser,   // func
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata,   // entry_key[15:0], entry_count[47:16], average[79:48]
	output logic [2:0]       m_axis_tuser,   // status
	output logic             m_axis_tlast,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_data
);
	import kaat_pkg::*;

	logic   enable_q;
	req_t   in_req;
	req_t   q_req;
	logic   q_valid, q_ready;
	res_t   res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			enable_q <= cfg_data;
		end
	end

	assign in_req = '{func_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[47:16]};

	kaat_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	kaat_back #(.SLOTS(SLOT_COUNT)) u_back (
		.clk(clk), .arst_n(arst_n), .enable(enable_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
	);

	assign m_axis_tdata = {8'd0, res.average, res.count, res.key};
	assign m_axis_tuser = res.status;
	assign m_axis_tlast = res.last;
endmodule
`default_nettype wire

@@ verif/keyed_average_aggregation_table_checker.sv @@
`timescale 1ns / 1ps
module keyed_average_aggregation_table_checker
	import kaat_pkg::*;
#(
	parameter int SLOT_COUNT = 56
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [87:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          flush_entries
);
	logic                       agg_enable;
	logic                       tbl_valid [SLOT_COUNT];
	logic [KEY_W-1:0]           tbl_key   [SLOT_COUNT];
	logic [CNT_W-1:0]           tbl_count [SLOT_COUNT];
	logic signed [SUM_W-1:0]    tbl_sum   [SLOT_COUNT];
	res_t                       expected_results[$];

	function automatic logic signed [SUM_W-1:0] sum_sat(logic signed [SUM_W-1:0] a,
			logic signed [SAMPLE_W-1:0] b);
		logic signed [SUM_W:0] wide;
		wide = $signed({a[SUM_W-1], a}) + $signed({{(SUM_W-SAMPLE_W+1){b[SAMPLE_W-1]}}, b});
		if (wide > $signed({1'b0, {1'b0, {(SUM_W-1){1'b1}}}}))
			return {1'b0, {(SUM_W-1){1'b1}}};
		if (wide < $signed({1'b1, {1'b1, {(SUM_W-1){1'b0}}}}))
			return {1'b1, {(SUM_W-1){1'b0}}};
		return wide[SUM_W-1:0];
	endfunction

	function automatic logic [AVG_W-1:0] mean_of(logic signed [SUM_W-1:0] s, logic [CNT_W-1:0] c);
		logic [SUM_W-1:0] mag, q;
		if (c == '0) return '0;
		mag = s[SUM_W-1] ? (~s + 1'b1) : s;
		q = mag / c;
		if (s[SUM_W-1]) begin
			if (q > 64'h8000_0000) q = 64'h8000_0000;
			return AVG_W'(~q + 1'b1);
		end
		if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
		return AVG_W'(q);
	endfunction

	task automatic predict_request(func_t fn, logic [KEY_W-1:0] k, logic signed [SAMPLE_W-1:0] v);
		res_t r;
		int total, n, hit, free;
		r = '0;
		r.last = 1'b1;
		r.key = k;
		if (fn == FN_ADD) begin
			hit = -1;
			free = -1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (tbl_valid[i] && tbl_key[i] == k && hit < 0) hit = i;
				if (!tbl_valid[i] && free < 0) free = i;
			end
			if (!agg_enable) begin
				r.status = ST_DIS;
			end else if (hit >= 0) begin
				if (tbl_count[hit] != '1) begin
					tbl_count[hit]++;
					tbl_sum[hit] = sum_sat(tbl_sum[hit], v);
				end
				r.status = ST_ACC;
				r.count = tbl_count[hit];
			end else if (free >= 0) begin
				tbl_valid[free] = 1'b1;
				tbl_key[free] = k;
				tbl_count[free] = CNT_W'(1);
				tbl_sum[free] = SUM_W'(v);
				r.status = ST_NEW;
				r.count = CNT_W'(1);
			end else begin
				r.status = ST_FULL;
			end
			expected_results.push_back(r);
			return;
		end
		total = 0;
		for (int i = 0; i < SLOT_COUNT; i++) if (tbl_valid[i]) total++;
		if (total == 0) begin
			r.status = ST_EMPTY;
			r.key = '0;
			expected_results.push_back(r);
			return;
		end
		n = 0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			if (!tbl_valid[i]) continue;
			n++;
			r.status = ST_ENTRY;
			r.key = tbl_key[i];
			r.count = tbl_count[i];
			r.average = mean_of(tbl_sum[i], tbl_count[i]);
			r.last = (n == total);
			expected_results.push_back(r);
			tbl_valid[i] = 1'b0;
			tbl_count[i] = '0;
			tbl_sum[i] = '0;
		end
	endtask

	assign pending = expected_results.size();

	always @(posedge clk or negedge arst_n) begin
		res_t got, want;
		if (!arst_n) begin
			agg_enable <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				tbl_valid[i] = 1'b0;
				tbl_key[i] = '0;
				tbl_count[i] = '0;
				tbl_sum[i] = '0;
			end
			expected_results.delete();
			errors <= 0;
			results_seen <= 0;
			flush_entries <= 0;
		end else begin
			if (cfg_valid && cfg_ready) agg_enable <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				predict_request(func_t'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[47:16]);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = status_t'(m_axis_tuser);
				got.key = m_axis_tdata[15:0];
				got.count = m_axis_tdata[47:16];
				got.average = m_axis_tdata[79:48];
				got.last = m_axis_tlast;
				results_seen <= results_seen + 1;
				if (got.status == ST_ENTRY) flush_entries <= flush_entries + 1;
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result st=%0d key=%h cnt=%h avg=%h last=%b",
							got.status, got.key, got.count, got.average, got.last);
					errors <= errors + 1;
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						if (errors < 10)
							$display("mismatch exp st=%0d key=%h cnt=%h avg=%h last=%b / got st=%0d key=%h cnt=%h avg=%h last=%b",
								want.status, want.key, want.count, want.average, want.last,
								got.status, got.key, got.count, got.average, got.last);
						errors <= errors + 1;
					end
				end
			end
		end
	end
endmodule

@@ verif/keyed_average_aggregation_table_top_tb.sv @@
`timescale 1ns / 1ps
module keyed_average_aggregation_table_top_tb;
	import kaat_pkg::*;

	localparam int SLOTS = 56;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	int          errors, pending, results_seen, flush_entries;
	int          requests_sent = 0;
	bit          idle_off = 1'b0;
	bit          hold_sink = 1'b0;
	logic [15:0] key_pool [8];

	always #5 clk = ~clk;

	keyed_average_aggregation_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	keyed_average_aggregation_table_checker #(.SLOT_COUNT(SLOTS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending), .results_seen(results_seen),
		.flush_entries(flush_entries)
	);

	// random ready bursts; long hold when requested
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end else if (!idle_off && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 14);
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				n = $urandom_range(1, 20);
				m_axis_tready <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_request(func_t fn, logic [15:0] k, logic [31:0] v);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= {v, k};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_enable(logic en);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// disabled adds, flush of empty table
		send_request(FN_ADD, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(FN_ADD, 16'h0000, 32'h8000_0000);
		send_request(FN_FLUSH, 16'h1234, 32'h0);
		drain_and_settle();
		write_enable(1'b1);
		// accumulate, extremes, negative truncation
		send_request(FN_ADD, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(FN_ADD, 16'hFFFF, 32'h7FFF_FFFF);
		send_request(FN_ADD, 16'h0000, 32'h8000_0000);
		send_request(FN_ADD, 16'h0000, 32'h8000_0000);
		send_request(FN_ADD, 16'h00AA, 32'hFFFF_FFFF);
		send_request(FN_ADD, 16'h00AA, 32'h0000_0000);
		send_request(FN_ADD, 16'h5555, 32'h5555_5555);
		send_request(FN_ADD, 16'hAAAA, 32'hAAAA_AAAA);
		send_request(FN_FLUSH, 16'h0, 32'h0);
		// fill the table, then overflow it
		for (int i = 0; i < SLOTS + 2; i++)
			send_request(FN_ADD, 16'(i * 977), $urandom);
		send_request(FN_FLUSH, 16'h0, 32'h0);
		drain_and_settle();
		write_enable(1'b0);
		// flush while disabled still reports slots
		send_request(FN_ADD, 16'h0042, 32'h1);
		drain_and_settle();
		write_enable(1'b1);
		send_request(FN_ADD, 16'h0042, 32'h0001_0000);
		drain_and_settle();
		write_enable(1'b0);
		send_request(FN_FLUSH, 16'h0, 32'h0);
		drain_and_settle();
		write_enable(1'b1);

		// backpressure: hold the sink while requests pile up
		hold_sink = 1'b1;
		fork
			begin
				repeat (2000) @(posedge clk);
				hold_sink = 1'b0;
			end
			for (int i = 0; i < 8; i++) send_request(FN_ADD, 16'(i), $urandom);
		join

		// random traffic over a small key pool, occasional flush and enable change
		for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
		for (int i = 0; i < 128; i++) begin
			if (i == 100) idle_off = 1'b1;
			if (i % 50 == 25) begin
				drain_and_settle();
				write_enable((i % 100) != 25);
			end
			if ($urandom_range(0, 11) == 0)
				send_request(FN_FLUSH, 16'($urandom), $urandom);
			else if ($urandom_range(0, 4) == 0)
				send_request(FN_ADD, 16'($urandom), rand_sample());
			else
				send_request(FN_ADD, key_pool[$urandom_range(0, 7)], rand_sample());
		end
		send_request(FN_FLUSH, 16'h0, 32'h0);
		drain_and_settle();

		$display("Sent %0d requests, checked %0d results (%0d flush entries).",
			requests_sent, results_seen, flush_entries);
		$display("Covered enable on/off, full table, empty flush, extremes and backpressure.");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#40ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

@@ filelist.f @@
design/kaat_pkg.sv
design/kaat_ram.sv
design/kaat_front.sv
design/kaat_div.sv
design/kaat_back.sv
design/keyed_average_aggregation_table_top.sv
verif/keyed_average_aggregation_table_checker.sv
verif/keyed_average_aggregation_table_top_tb.sv
